/* sv/dwt53_pkg.sv */
// ----------------------------------------------------------------------------
// dwt53_pkg: shared types and constants for the reversible 5/3 lifting DWT
// Holds the coefficient format, the result record and the buffer sizing.
// ----------------------------------------------------------------------------
package dwt53_pkg;

    localparam int DEFAULT_SAMPLE_BITS = 16;

    // Emitted coefficients are saturated to this signed width.
    localparam int COEF_BITS = 18;
    localparam int COEF_MAX  = 131071;
    localparam int COEF_MIN  = -131072;

    // One sample can produce at most this many coefficients.
    localparam int MAX_RESULTS = 3;

    // Result buffer depth, a power of two.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

    typedef enum logic {
        BAND_LOW  = 1'b0,
        BAND_HIGH = 1'b1
    } t_band;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] coefficient;
        t_band                       band;
        logic                        line_end;
    } t_result;

endpackage

/* sv/dwt53_in_if.sv */
// ----------------------------------------------------------------------------
// dwt53_in_if: sample input channel
// Carries one signed sample and its end-of-line mark per beat.
// ----------------------------------------------------------------------------
interface dwt53_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

/* sv/dwt53_out_if.sv */
// ----------------------------------------------------------------------------
// dwt53_out_if: coefficient output channel
// Carries one saturated coefficient with band flag and line end per beat.
// ----------------------------------------------------------------------------
interface dwt53_out_if
    import dwt53_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic signed [COEF_BITS-1:0] coefficient;
    logic                        band;
    logic                        line_end;

    modport source (output valid, output coefficient, output band, output line_end,
                    input ready);
    modport sink   (input valid, input coefficient, input band, input line_end,
                    output ready);
endinterface

/* sv/dwt53_cfg_if.sv */
// ----------------------------------------------------------------------------
// dwt53_cfg_if: configuration write channel
// Carries the start_odd register value on each write beat.
// ----------------------------------------------------------------------------
interface dwt53_cfg_if;
    logic valid;
    logic ready;
    logic start_odd;

    modport source (output valid, output start_odd, input ready);
    modport sink   (input valid, input start_odd, output ready);
endinterface

/* sv/dwt53_result_fifo.sv */
// ----------------------------------------------------------------------------
// dwt53_result_fifo: result buffer with up to three writes per cycle
// Takes a burst of coefficients from the lifting stage and hands them out
// one beat per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module dwt53_result_fifo
    import dwt53_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_result                    i_push_data [MAX_RESULTS],
    input  logic [1:0]                 i_push_count,
    output logic [FIFO_PTR_BITS:0]     o_count,
    dwt53_out_if.source                o_out
);

    t_result                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [FIFO_PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [FIFO_PTR_BITS:0]   r_count, n_count;
    logic                     pop;
    t_result                  head;

    assign head              = r_mem[r_rd_ptr];
    assign o_out.valid       = (r_count != '0);
    assign o_out.coefficient = head.coefficient;
    assign o_out.band        = head.band;
    assign o_out.line_end    = head.line_end;
    assign pop               = o_out.valid && o_out.ready;
    assign o_count           = r_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr + FIFO_PTR_BITS'(i_push_count);
        n_rd_ptr = r_rd_ptr + FIFO_PTR_BITS'(pop);
        n_count  = r_count + (FIFO_PTR_BITS + 1)'(i_push_count)
                 - (FIFO_PTR_BITS + 1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (k < int'(i_push_count)) begin
                r_mem[r_wr_ptr + FIFO_PTR_BITS'(k)] <= i_push_data[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // The fill level and the pointer distance must always agree.
    a_count_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) == r_count[FIFO_PTR_BITS-1:0])
        else $error("result buffer fill level disagrees with pointers");

    // The buffer never fills past its depth.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (FIFO_PTR_BITS + 1)'(FIFO_DEPTH))
        else $error("result buffer overflow");

endmodule

/* sv/dwt_reversible_53_lifting.sv */
// ----------------------------------------------------------------------------
// dwt_reversible_53_lifting: streaming forward reversible 5/3 wavelet lifting
//
// Samples of one line or column enter on i_in, one per beat, in position
// order; i_in.last marks the final sample of the line. Coefficients leave on
// o_out in position order, each tagged with its band (low or high pass) and
// a line_end flag on the final coefficient of the line. The i_cfg channel
// writes start_odd, which says whether the first sample of a line sits at an
// odd (high-pass) position; it is sampled when a line's first sample is
// processed and is always ready.
//
// Throughput is one sample per cycle while the result buffer has room for a
// worst-case burst. A sample is registered in the input stage and lifted
// there, and its coefficients are written into the result buffer as the stage
// moves on; o_out shows the buffer head. A line end can release up to three
// coefficients at once; they go into an eight-entry result buffer that drains
// one beat per cycle while the receiver is ready, and the input stage holds
// when fewer than three slots are free. A stalled receiver therefore backs
// up into the buffer and then into i_in.ready.
// Reset clears the line state, start_odd and the buffer.
// ----------------------------------------------------------------------------
module dwt_reversible_53_lifting
    import dwt53_pkg::*;
#(
    parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dwt53_cfg_if.sink              i_cfg,
    dwt53_in_if.sink               i_in,
    dwt53_out_if.source            o_out
);

    // Internal width covers every intermediate lifting value exactly.
    localparam int CW = SAMPLE_BITS + 3;
    localparam int EW = (CW > COEF_BITS) ? CW : COEF_BITS;
    localparam logic signed [CW-1:0] TWO    = CW'(2);
    localparam logic signed [EW-1:0] SAT_HI = EW'(COEF_MAX);
    localparam logic signed [EW-1:0] SAT_LO = EW'(COEF_MIN);

    // Configuration register.
    logic r_start_odd;

    // Input stage.
    logic                          r_v;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                          r_last;
    logic                          stage_go;

    // Line state.
    logic signed [SAMPLE_BITS-1:0] r_h0, n_h0;
    logic signed [SAMPLE_BITS-1:0] r_h1, n_h1;
    logic signed [CW-1:0]          r_lh, n_lh;
    logic [1:0]                    r_cnt, n_cnt;
    logic                          r_next_odd, n_next_odd;

    // Lifting results for the item in the stage.
    logic signed [CW-1:0] res_coef [MAX_RESULTS];
    t_band                res_band [MAX_RESULTS];
    logic                 res_end  [MAX_RESULTS];
    logic [1:0]           res_n;
    logic                 odd;
    t_result              push_data [MAX_RESULTS];
    logic [1:0]           push_count;
    logic [FIFO_PTR_BITS:0] fifo_count;

    function automatic logic signed [COEF_BITS-1:0] saturate(
        input logic signed [CW-1:0] v
    );
        logic signed [EW-1:0] ve;
        ve = EW'(v);
        if (ve > SAT_HI) begin
            ve = SAT_HI;
        end else if (ve < SAT_LO) begin
            ve = SAT_LO;
        end
        return ve[COEF_BITS-1:0];
    endfunction

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_odd <= 1'b0;
        end else if (i_cfg.valid) begin
            r_start_odd <= i_cfg.start_odd;
        end
    end

    // The stage moves on only when the buffer can take a worst-case burst.
    assign stage_go   = r_v && (fifo_count <= (FIFO_PTR_BITS + 1)'(FIFO_DEPTH - MAX_RESULTS));
    assign i_in.ready = !r_v || stage_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_v <= 1'b1;
        end else if (stage_go) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_sample <= i_in.sample;
            r_last   <= i_in.last;
        end
    end

    assign odd = (r_cnt == 2'd0) ? r_start_odd : r_next_odd;

    // Lifting: H = xo - floor((xl + xr) / 2), L = xe + floor((Hl + Hr + 2) / 4).
    // Missing neighbors at the line ends are mirrored.
    always_comb begin
        logic signed [CW-1:0] x, h0, h1, d, dl, xl;
        x  = CW'(r_sample);
        h0 = CW'(r_h0);
        h1 = CW'(r_h1);
        d  = '0;
        dl = '0;
        xl = '0;
        res_n = 2'd0;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            res_coef[k] = '0;
            res_band[k] = BAND_LOW;
            res_end[k]  = 1'b0;
        end
        n_h0       = r_h0;
        n_h1       = r_h1;
        n_lh       = r_lh;
        n_cnt      = r_cnt;
        n_next_odd = r_next_odd;

        if (odd) begin
            if (!r_last) begin
                n_h1       = r_h0;
                n_h0       = r_sample;
                n_cnt      = (r_cnt == 2'd3) ? 2'd3 : r_cnt + 2'd1;
                n_next_odd = 1'b0;
            end else begin
                if (r_cnt == 2'd0) begin
                    // A lone odd sample is doubled.
                    res_coef[0] = x + x;
                    res_band[0] = BAND_HIGH;
                    res_end[0]  = 1'b1;
                    res_n       = 2'd1;
                end else begin
                    d  = x - h0;
                    dl = (r_cnt >= 2'd2) ? r_lh : d;
                    res_coef[0] = h0 + ((dl + d + TWO) >>> 2);
                    res_band[0] = BAND_LOW;
                    res_coef[1] = d;
                    res_band[1] = BAND_HIGH;
                    res_end[1]  = 1'b1;
                    res_n       = 2'd2;
                end
                n_h0       = '0;
                n_h1       = '0;
                n_lh       = '0;
                n_cnt      = 2'd0;
                n_next_odd = 1'b0;
            end
        end else begin
            if (r_cnt >= 2'd1) begin
                xl = (r_cnt >= 2'd2) ? h1 : x;
                d  = h0 - ((xl + x) >>> 1);
                if (r_cnt >= 2'd2) begin
                    dl = (r_cnt == 2'd3) ? r_lh : d;
                    res_coef[res_n] = xl + ((dl + d + TWO) >>> 2);
                    res_band[res_n] = BAND_LOW;
                    res_n           = res_n + 2'd1;
                end
                res_coef[res_n] = d;
                res_band[res_n] = BAND_HIGH;
                res_n           = res_n + 2'd1;
                n_lh            = d;
            end
            if (r_last) begin
                res_coef[res_n] = (r_cnt == 2'd0) ? x : x + ((d + d + TWO) >>> 2);
                res_band[res_n] = BAND_LOW;
                res_end[res_n]  = 1'b1;
                res_n           = res_n + 2'd1;
                n_h0       = '0;
                n_h1       = '0;
                n_lh       = '0;
                n_cnt      = 2'd0;
                n_next_odd = 1'b0;
            end else begin
                n_h1       = r_h0;
                n_h0       = r_sample;
                n_cnt      = (r_cnt == 2'd3) ? 2'd3 : r_cnt + 2'd1;
                n_next_odd = 1'b1;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            push_data[k].coefficient = saturate(res_coef[k]);
            push_data[k].band        = res_band[k];
            push_data[k].line_end    = res_end[k];
        end
        push_count = stage_go ? res_n : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h0       <= '0;
            r_h1       <= '0;
            r_lh       <= '0;
            r_cnt      <= 2'd0;
            r_next_odd <= 1'b0;
        end else if (stage_go) begin
            r_h0       <= n_h0;
            r_h1       <= n_h1;
            r_lh       <= n_lh;
            r_cnt      <= n_cnt;
            r_next_odd <= n_next_odd;
        end
    end

    dwt53_result_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_data  (push_data),
        .i_push_count (push_count),
        .o_count      (fifo_count),
        .o_out        (o_out)
    );

    // An odd-position sample that does not end the line emits nothing.
    a_odd_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stage_go && odd && !r_last) |-> (res_n == 2'd0))
        else $error("odd mid-line sample produced coefficients");

    // Every processed line end restarts the line state.
    a_line_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stage_go && r_last) |=> (r_cnt == 2'd0 && !r_next_odd))
        else $error("line state not cleared after line end");

    // A processed line end always produces at least one coefficient.
    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stage_go && r_last) |-> (push_count != 2'd0))
        else $error("line end produced no coefficient");

endmodule
